FILE: rtl/tabe_pkg.sv
// shared types, constants and a decode helper for the thumb execute block
`timescale 1ns / 1ps

package tabe_pkg;

    // register file geometry
    localparam int          RegCount = 15;
    localparam int          RegIdxW  = 4;
    localparam logic [3:0]  PcIdx    = 4'd15;
    localparam logic [3:0]  LrIdx    = 4'd14;

    // coarse instruction class, from the top six opcode bits
    typedef enum logic [2:0] {
        CLS_SHIFT_ADDSUB = 3'd0,
        CLS_IMM8         = 3'd1,
        CLS_ALU          = 3'd2,
        CLS_HIREG        = 3'd3,
        CLS_BCOND        = 3'd4,
        CLS_BL_HI        = 3'd5,
        CLS_BL_LO        = 3'd6,
        CLS_OTHER        = 3'd7
    } instr_class_t;

    // condition flags
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // everything one instruction produces
    typedef struct packed {
        logic                 we;
        logic [RegIdxW-1:0]   widx;
        logic [31:0]          wval;
        flags_t               flags;
        logic                 taken;
        logic [31:0]          npc;
        logic                 thumb;
        logic                 unsup;
    } exec_result_t;

    function automatic instr_class_t decode_class(input logic [15:0] instr);
        instr_class_t cls;
        unique casez (instr[15:10])
            6'b000???: cls = CLS_SHIFT_ADDSUB;
            6'b001???: cls = CLS_IMM8;
            6'b010000: cls = CLS_ALU;
            6'b010001: cls = CLS_HIREG;
            6'b1101??: cls = CLS_BCOND;
            6'b11110?: cls = CLS_BL_HI;
            6'b11111?: cls = CLS_BL_LO;
            default:   cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

FILE: rtl/tabe_regfile.sv
// register file r0..r14: synchronous two-read one-write memory with write bypass
`timescale 1ns / 1ps

module tabe_regfile (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [tabe_pkg::RegIdxW-1:0]  rd_addr_a,
    input  logic [tabe_pkg::RegIdxW-1:0]  rd_addr_b,
    output logic [31:0]                   rd_data_a,
    output logic [31:0]                   rd_data_b,
    input  logic                          wr_en,
    input  logic [tabe_pkg::RegIdxW-1:0]  wr_addr,
    input  logic [31:0]                   wr_data
);

    logic [31:0]                   rf_mem [tabe_pkg::RegCount];
    logic [tabe_pkg::RegCount-1:0] valid_reg;

    logic [31:0]                   q_a_reg, q_b_reg;
    logic                          hit_a_reg, hit_b_reg;
    logic [tabe_pkg::RegIdxW-1:0]  addr_a_reg, addr_b_reg;

    logic                          byp_valid_reg;
    logic [tabe_pkg::RegIdxW-1:0]  byp_addr_reg;
    logic [31:0]                   byp_data_reg;

    logic                          wr_ok;

    assign wr_ok = wr_en && (wr_addr != tabe_pkg::PcIdx);

    // memory write port
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            rf_mem[wr_addr] <= wr_data;
        end
    end

    // memory read ports, index 15 is never looked up
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
            if (rd_addr_a != tabe_pkg::PcIdx) begin
                q_a_reg <= rf_mem[rd_addr_a];
            end
            if (rd_addr_b != tabe_pkg::PcIdx) begin
                q_b_reg <= rf_mem[rd_addr_b];
            end
        end
    end

    // per-entry written marks, an unwritten entry reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            if (wr_ok) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_a_reg <= 1'b0;
                hit_b_reg <= 1'b0;
                if (rd_addr_a != tabe_pkg::PcIdx) begin
                    hit_a_reg <= valid_reg[rd_addr_a];
                end
                if (rd_addr_b != tabe_pkg::PcIdx) begin
                    hit_b_reg <= valid_reg[rd_addr_b];
                end
            end
        end
    end

    // last write kept for read-during-write forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (wr_ok) begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_data;
        end
    end

    // read data with forwarding
    always_comb begin
        if (byp_valid_reg && (byp_addr_reg == addr_a_reg)) begin
            rd_data_a = byp_data_reg;
        end else begin
            rd_data_a = hit_a_reg ? q_a_reg : '0;
        end
        if (byp_valid_reg && (byp_addr_reg == addr_b_reg)) begin
            rd_data_b = byp_data_reg;
        end else begin
            rd_data_b = hit_b_reg ? q_b_reg : '0;
        end
    end

endmodule

FILE: rtl/tabe_exec.sv
// execute logic: shifter, adder, branch target and result selection
`timescale 1ns / 1ps

module tabe_exec (
    input  logic [15:0]             instr,
    input  logic [31:0]             pc,
    input  logic [31:0]             op_a,
    input  logic [31:0]             op_b,
    input  tabe_pkg::flags_t        flags_in,
    output tabe_pkg::exec_result_t  res
);

    // sub-opcodes
    localparam logic [1:0] ShLsl    = 2'd0;
    localparam logic [1:0] ShLsr    = 2'd1;
    localparam logic [1:0] ShAddSub = 2'd3;
    localparam logic [1:0] ImMov    = 2'd0;
    localparam logic [1:0] ImCmp    = 2'd1;
    localparam logic [1:0] ImAdd    = 2'd2;
    localparam logic [3:0] AluCmp   = 4'd10;
    localparam logic [3:0] AluBic   = 4'd14;
    localparam logic [1:0] HiMov    = 2'd2;
    localparam logic [1:0] HiBx     = 2'd3;
    localparam logic [3:0] CondFirstBad = 4'd14;

    typedef enum logic [3:0] {
        CC_EQ = 4'd0,  CC_NE = 4'd1,  CC_CS = 4'd2,  CC_CC = 4'd3,
        CC_MI = 4'd4,  CC_PL = 4'd5,  CC_VS = 4'd6,  CC_VC = 4'd7,
        CC_HI = 4'd8,  CC_LS = 4'd9,  CC_GE = 4'd10, CC_LT = 4'd11,
        CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
    } cond_t;

    function automatic logic cond_pass(input cond_t cc, input tabe_pkg::flags_t f);
        logic p;
        unique case (cc)
            CC_EQ:   p = f.z;
            CC_NE:   p = !f.z;
            CC_CS:   p = f.c;
            CC_CC:   p = !f.c;
            CC_MI:   p = f.n;
            CC_PL:   p = !f.n;
            CC_VS:   p = f.v;
            CC_VC:   p = !f.v;
            CC_HI:   p = f.c && !f.z;
            CC_LS:   p = !f.c || f.z;
            CC_GE:   p = (f.n == f.v);
            CC_LT:   p = (f.n != f.v);
            CC_GT:   p = !f.z && (f.n == f.v);
            default: p = f.z || (f.n != f.v);
        endcase
        return p;
    endfunction

    tabe_pkg::instr_class_t cls;
    logic [1:0]   kind;
    logic [7:0]   imm8;
    logic [10:0]  imm11;
    logic [4:0]   sh;
    logic [5:0]   sh_eff;
    logic [32:0]  lsl_t, lsr_t, asr_t;
    logic [31:0]  add_b, add_b_eff;
    logic         add_sub;
    logic [32:0]  sum;
    tabe_pkg::flags_t add_flags;
    logic [31:0]  pc_plus2, tgt_base, tgt_off, tgt;
    logic [3:0]   hi_dst;
    logic [31:0]  bic_val;

    assign cls   = tabe_pkg::decode_class(instr);
    assign kind  = instr[12:11];
    assign imm8  = instr[7:0];
    assign imm11 = instr[10:0];
    assign sh    = instr[10:6];

    // barrel shifter, a zero amount on LSR/ASR means 32
    always_comb begin
        sh_eff = (sh == 5'd0) ? 6'd32 : {1'b0, sh};
        lsl_t  = {1'b0, op_a} << sh;
        lsr_t  = {op_a, 1'b0} >> sh_eff;
        asr_t  = 33'($signed({op_a, 1'b0}) >>> sh_eff);
    end

    // shared adder, subtract as a + ~b + 1 so carry is not-borrow
    always_comb begin
        add_b   = op_b;
        add_sub = 1'b1;
        unique case (cls)
            tabe_pkg::CLS_SHIFT_ADDSUB: add_sub = instr[9];
            tabe_pkg::CLS_IMM8: begin
                add_b   = {24'd0, imm8};
                add_sub = (kind != ImAdd);
            end
            default: add_sub = 1'b1;
        endcase
        add_b_eff   = add_sub ? ~add_b : add_b;
        sum         = {1'b0, op_a} + {1'b0, add_b_eff} + {32'd0, add_sub};
        add_flags.n = sum[31];
        add_flags.z = (sum[31:0] == 32'd0);
        add_flags.c = sum[32];
        add_flags.v = (op_a[31] == add_b_eff[31]) && (sum[31] != op_a[31]);
    end

    // branch and link target adder
    always_comb begin
        pc_plus2 = pc + 32'd2;
        tgt_base = pc_plus2;
        tgt_off  = {{23{imm8[7]}}, imm8, 1'b0};
        unique case (cls)
            tabe_pkg::CLS_BL_HI: tgt_off = {{9{imm11[10]}}, imm11, 12'd0};
            tabe_pkg::CLS_BL_LO: begin
                tgt_base = op_a;
                tgt_off  = {20'd0, imm11, 1'b0};
            end
            default: tgt_off = {{23{imm8[7]}}, imm8, 1'b0};
        endcase
        tgt = tgt_base + tgt_off;
    end

    assign hi_dst  = {instr[7], instr[2:0]};
    assign bic_val = op_a & ~op_b;

    // result selection
    always_comb begin
        res       = '0;
        res.flags = flags_in;
        res.npc   = pc;
        res.thumb = 1'b1;
        unique case (cls)
            tabe_pkg::CLS_SHIFT_ADDSUB: begin
                if (kind == ShAddSub) begin
                    if (instr[10]) begin
                        res.unsup = 1'b1;
                    end else begin
                        res.we    = 1'b1;
                        res.widx  = {1'b0, instr[2:0]};
                        res.wval  = sum[31:0];
                        res.flags = add_flags;
                    end
                end else begin
                    res.we   = 1'b1;
                    res.widx = {1'b0, instr[2:0]};
                    unique case (kind)
                        ShLsl: begin
                            if (sh == 5'd0) begin
                                res.wval = op_a;
                            end else begin
                                res.wval    = lsl_t[31:0];
                                res.flags.c = lsl_t[32];
                            end
                        end
                        ShLsr: begin
                            res.wval    = lsr_t[32:1];
                            res.flags.c = lsr_t[0];
                        end
                        default: begin
                            res.wval    = asr_t[32:1];
                            res.flags.c = asr_t[0];
                        end
                    endcase
                    res.flags.n = res.wval[31];
                    res.flags.z = (res.wval == 32'd0);
                end
            end
            tabe_pkg::CLS_IMM8: begin
                unique case (kind)
                    ImMov: begin
                        res.we      = 1'b1;
                        res.widx    = {1'b0, instr[10:8]};
                        res.wval    = {24'd0, imm8};
                        res.flags.n = 1'b0;
                        res.flags.z = (imm8 == 8'd0);
                    end
                    ImCmp: res.flags = add_flags;
                    default: begin
                        res.we    = 1'b1;
                        res.widx  = {1'b0, instr[10:8]};
                        res.wval  = sum[31:0];
                        res.flags = add_flags;
                    end
                endcase
            end
            tabe_pkg::CLS_ALU: begin
                if (instr[9:6] == AluCmp) begin
                    res.flags = add_flags;
                end else if (instr[9:6] == AluBic) begin
                    res.we      = 1'b1;
                    res.widx    = {1'b0, instr[2:0]};
                    res.wval    = bic_val;
                    res.flags.n = bic_val[31];
                    res.flags.z = (bic_val == 32'd0);
                end else begin
                    res.unsup = 1'b1;
                end
            end
            tabe_pkg::CLS_HIREG: begin
                if (instr[9:8] == HiMov) begin
                    if (hi_dst == tabe_pkg::PcIdx) begin
                        res.taken = 1'b1;
                        res.npc   = {op_a[31:1], 1'b0};
                    end else begin
                        res.we   = 1'b1;
                        res.widx = hi_dst;
                        res.wval = op_a;
                    end
                end else if (instr[9:8] == HiBx) begin
                    res.taken = 1'b1;
                    res.npc   = {op_a[31:1], 1'b0};
                    res.thumb = op_a[0];
                end else begin
                    res.unsup = 1'b1;
                end
            end
            tabe_pkg::CLS_BCOND: begin
                if (instr[11:8] >= CondFirstBad) begin
                    res.unsup = 1'b1;
                end else if (cond_pass(cond_t'(instr[11:8]), flags_in)) begin
                    res.taken = 1'b1;
                    res.npc   = tgt;
                end
            end
            tabe_pkg::CLS_BL_HI: begin
                res.we   = 1'b1;
                res.widx = tabe_pkg::LrIdx;
                res.wval = tgt;
            end
            tabe_pkg::CLS_BL_LO: begin
                res.taken = 1'b1;
                res.npc   = tgt;
                res.we    = 1'b1;
                res.widx  = tabe_pkg::LrIdx;
                res.wval  = {pc[31:1], 1'b1};
            end
            default: res.unsup = 1'b1;
        endcase
    end

endmodule

FILE: rtl/thumb_alu_branch_execute_top.sv
// top level of the thumb execute block: handshakes, execute stage, flags and output register
// pipeline: execute-stage registers, then the output register on m_*; throughput: one
// transaction per cycle while the output is not stalled; register file read at accept,
// execute and write-back in the execute stage, last write forwarded to the next read
// reset: synchronous active-low aresetn clears all pipeline valids, the flags and the
// register-file written marks, so r0..r14 read as zero until written
`timescale 1ns / 1ps

module thumb_alu_branch_execute_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instr,
    input  logic [31:0] s_pc_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_write_en,
    output logic [3:0]  m_write_reg,
    output logic [31:0] m_reg_value,
    output logic        m_flag_n,
    output logic        m_flag_z,
    output logic        m_flag_c,
    output logic        m_flag_v,
    output logic        m_branch_taken,
    output logic [31:0] m_next_pc,
    output logic        m_thumb_mode,
    output logic        m_unsupported
);

    logic                          accept_in;
    logic                          out_free;
    logic                          s1_advance;
    logic [tabe_pkg::RegIdxW-1:0]  rd_addr_a, rd_addr_b;
    logic [31:0]                   rf_data_a, rf_data_b;
    logic [31:0]                   op_a, op_b;
    tabe_pkg::exec_result_t        res;

    logic                          s1_valid_reg;
    logic [15:0]                   s1_instr_reg;
    logic [31:0]                   s1_pc_reg;
    logic [tabe_pkg::RegIdxW-1:0]  s1_addr_a_reg, s1_addr_b_reg;

    tabe_pkg::flags_t              flags_reg;
    logic                          m_valid_reg;
    tabe_pkg::exec_result_t        m_res_reg;

    // handshake
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign accept_in  = s_valid && s_ready;

    // operand addresses from the incoming instruction
    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        unique case (tabe_pkg::decode_class(s_instr))
            tabe_pkg::CLS_SHIFT_ADDSUB: begin
                rd_addr_a = {1'b0, s_instr[5:3]};
                rd_addr_b = {1'b0, s_instr[8:6]};
            end
            tabe_pkg::CLS_IMM8:  rd_addr_a = {1'b0, s_instr[10:8]};
            tabe_pkg::CLS_ALU: begin
                rd_addr_a = {1'b0, s_instr[2:0]};
                rd_addr_b = {1'b0, s_instr[5:3]};
            end
            tabe_pkg::CLS_HIREG: rd_addr_a = {s_instr[6], s_instr[5:3]};
            tabe_pkg::CLS_BL_LO: rd_addr_a = tabe_pkg::LrIdx;
            default: begin
                rd_addr_a = '0;
                rd_addr_b = '0;
            end
        endcase
    end

    tabe_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept_in),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rf_data_a),
        .rd_data_b (rf_data_b),
        .wr_en     (s1_advance && res.we),
        .wr_addr   (res.widx),
        .wr_data   (res.wval)
    );

    // execute stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept_in) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            s1_instr_reg  <= s_instr;
            s1_pc_reg     <= s_pc_value;
            s1_addr_a_reg <= rd_addr_a;
            s1_addr_b_reg <= rd_addr_b;
        end
    end

    // r15 reads as the instruction's pc
    assign op_a = (s1_addr_a_reg == tabe_pkg::PcIdx) ? s1_pc_reg : rf_data_a;
    assign op_b = (s1_addr_b_reg == tabe_pkg::PcIdx) ? s1_pc_reg : rf_data_b;

    tabe_exec u_exec (
        .instr    (s1_instr_reg),
        .pc       (s1_pc_reg),
        .op_a     (op_a),
        .op_b     (op_b),
        .flags_in (flags_reg),
        .res      (res)
    );

    // status flags commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (s1_advance) begin
            flags_reg <= res.flags;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_reg_write_en = m_res_reg.we;
    assign m_write_reg    = m_res_reg.widx;
    assign m_reg_value    = m_res_reg.wval;
    assign m_flag_n       = m_res_reg.flags.n;
    assign m_flag_z       = m_res_reg.flags.z;
    assign m_flag_c       = m_res_reg.flags.c;
    assign m_flag_v       = m_res_reg.flags.v;
    assign m_branch_taken = m_res_reg.taken;
    assign m_next_pc      = m_res_reg.npc;
    assign m_thumb_mode   = m_res_reg.thumb;
    assign m_unsupported  = m_res_reg.unsup;

    // checks
    a_no_pc_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.we |-> m_res_reg.widx != tabe_pkg::PcIdx)
        else $error("register write targets r15");

    a_unsup_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.unsup |-> !m_res_reg.we && !m_res_reg.taken)
        else $error("unsupported transaction writes or branches");

    a_arm_needs_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_res_reg.thumb |-> m_res_reg.taken)
        else $error("state change without branch");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");

    a_flags_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_advance |=> $stable(flags_reg))
        else $error("flags changed without a commit");

endmodule

FILE: verif/thumb_exec_checker.sv
// instruction codes shared by the bench, and the checker that predicts and compares every result
`timescale 1ns / 1ps

package thumb_exec_codes_pkg;

    // shift / add-subtract group, bits 12:11
    typedef enum logic [1:0] {
        SH_LSL    = 2'd0,
        SH_LSR    = 2'd1,
        SH_ASR    = 2'd2,
        SH_ADDSUB = 2'd3
    } shift_kind_t;

    // move / compare / add / subtract immediate group, bits 12:11
    typedef enum logic [1:0] {
        IMM_MOV = 2'd0,
        IMM_CMP = 2'd1,
        IMM_ADD = 2'd2,
        IMM_SUB = 2'd3
    } imm8_kind_t;

    // data-processing group, bits 9:6
    typedef enum logic [3:0] {
        ALU_AND = 4'd0,
        ALU_EOR = 4'd1,
        ALU_LSL = 4'd2,
        ALU_LSR = 4'd3,
        ALU_ASR = 4'd4,
        ALU_ADC = 4'd5,
        ALU_SBC = 4'd6,
        ALU_ROR = 4'd7,
        ALU_TST = 4'd8,
        ALU_NEG = 4'd9,
        ALU_CMP = 4'd10,
        ALU_CMN = 4'd11,
        ALU_ORR = 4'd12,
        ALU_MUL = 4'd13,
        ALU_BIC = 4'd14,
        ALU_MVN = 4'd15
    } alu_op_t;

    // high-register group, bits 9:8
    typedef enum logic [1:0] {
        HI_ADD = 2'd0,
        HI_CMP = 2'd1,
        HI_MOV = 2'd2,
        HI_BX  = 2'd3
    } hireg_kind_t;

    // branch conditions, bits 11:8
    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } cond_t;

endpackage

module thumb_exec_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_instr,
    input  logic [31:0] s_pc_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_reg_write_en,
    input  logic [3:0]  m_write_reg,
    input  logic [31:0] m_reg_value,
    input  logic        m_flag_n,
    input  logic        m_flag_z,
    input  logic        m_flag_c,
    input  logic        m_flag_v,
    input  logic        m_branch_taken,
    input  logic [31:0] m_next_pc,
    input  logic        m_thumb_mode,
    input  logic        m_unsupported,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          redirects_seen,
    output int          arm_exits_seen,
    output int          unsupported_seen
);

    // shadow architectural state
    logic [31:0]            gpr [tabe_pkg::RegCount];
    tabe_pkg::flags_t       nzcv;
    tabe_pkg::exec_result_t pending_results [$];
    tabe_pkg::exec_result_t oldest;

    initial begin
        fail_count       = 0;
        pending          = 0;
        results_checked  = 0;
        redirects_seen   = 0;
        arm_exits_seen   = 0;
        unsupported_seen = 0;
    end

    // operand read, with index 15 giving the pc of this instruction
    function automatic logic [31:0] read_gpr(input logic [3:0] idx, input logic [31:0] pc);
        return (idx == tabe_pkg::PcIdx) ? pc : gpr[idx];
    endfunction

    function automatic void set_nz(input logic [31:0] r);
        nzcv.n = r[31];
        nzcv.z = (r == 32'd0);
    endfunction

    function automatic logic [31:0] add_nzcv(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        set_nz(s[31:0]);
        nzcv.c = s[32];
        nzcv.v = (a[31] == b[31]) && (s[31] != a[31]);
        return s[31:0];
    endfunction

    // carry is arm no-borrow
    function automatic logic [31:0] sub_nzcv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        r = a - b;
        set_nz(r);
        nzcv.c = (a >= b);
        nzcv.v = (a[31] != b[31]) && (r[31] != a[31]);
        return r;
    endfunction

    function automatic logic cond_holds(input thumb_exec_codes_pkg::cond_t cond);
        case (cond)
            thumb_exec_codes_pkg::COND_EQ: return nzcv.z;
            thumb_exec_codes_pkg::COND_NE: return !nzcv.z;
            thumb_exec_codes_pkg::COND_CS: return nzcv.c;
            thumb_exec_codes_pkg::COND_CC: return !nzcv.c;
            thumb_exec_codes_pkg::COND_MI: return nzcv.n;
            thumb_exec_codes_pkg::COND_PL: return !nzcv.n;
            thumb_exec_codes_pkg::COND_VS: return nzcv.v;
            thumb_exec_codes_pkg::COND_VC: return !nzcv.v;
            thumb_exec_codes_pkg::COND_HI: return nzcv.c && !nzcv.z;
            thumb_exec_codes_pkg::COND_LS: return !nzcv.c || nzcv.z;
            thumb_exec_codes_pkg::COND_GE: return nzcv.n == nzcv.v;
            thumb_exec_codes_pkg::COND_LT: return nzcv.n != nzcv.v;
            thumb_exec_codes_pkg::COND_GT: return !nzcv.z && (nzcv.n == nzcv.v);
            default: return nzcv.z || (nzcv.n != nzcv.v);
        endcase
    endfunction

    function automatic tabe_pkg::instr_class_t decode_group(input logic [15:0] op);
        casez (op[15:10])
            6'b000???: return tabe_pkg::CLS_SHIFT_ADDSUB;
            6'b001???: return tabe_pkg::CLS_IMM8;
            6'b010000: return tabe_pkg::CLS_ALU;
            6'b010001: return tabe_pkg::CLS_HIREG;
            6'b1101??: return tabe_pkg::CLS_BCOND;
            6'b11110?: return tabe_pkg::CLS_BL_HI;
            6'b11111?: return tabe_pkg::CLS_BL_LO;
            default:   return tabe_pkg::CLS_OTHER;
        endcase
    endfunction

    // executes one instruction on the shadow state and returns what the block should report
    function automatic tabe_pkg::exec_result_t execute_instr(input logic [15:0] op,
                                                             input logic [31:0] pc);
        tabe_pkg::exec_result_t res;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  r;
        logic [4:0]   sh;
        logic [3:0]   src;
        logic [3:0]   dst;
        logic         c;
        res       = '0;
        res.npc   = pc;
        res.thumb = 1'b1;
        case (decode_group(op))
            tabe_pkg::CLS_SHIFT_ADDSUB: begin
                a  = read_gpr({1'b0, op[5:3]}, pc);
                sh = op[10:6];
                if (thumb_exec_codes_pkg::shift_kind_t'(op[12:11]) ==
                    thumb_exec_codes_pkg::SH_ADDSUB) begin
                    // three-bit immediate form is not executed
                    if (op[10]) begin
                        res.unsup = 1'b1;
                    end else begin
                        b = read_gpr({1'b0, op[8:6]}, pc);
                        res.wval = op[9] ? sub_nzcv(a, b) : add_nzcv(a, b);
                        res.we   = 1'b1;
                        res.widx = {1'b0, op[2:0]};
                    end
                end else begin
                    // zero shift: lsl keeps value and carry, lsr and asr shift by 32
                    c = nzcv.c;
                    case (thumb_exec_codes_pkg::shift_kind_t'(op[12:11]))
                        thumb_exec_codes_pkg::SH_LSL: begin
                            if (sh == 5'd0) begin
                                r = a;
                            end else begin
                                c = a[32 - sh];
                                r = a << sh;
                            end
                        end
                        thumb_exec_codes_pkg::SH_LSR: begin
                            if (sh == 5'd0) begin
                                c = a[31];
                                r = 32'd0;
                            end else begin
                                c = a[sh - 1];
                                r = a >> sh;
                            end
                        end
                        default: begin
                            if (sh == 5'd0) begin
                                c = a[31];
                                r = {32{a[31]}};
                            end else begin
                                c = a[sh - 1];
                                r = $unsigned($signed(a) >>> sh);
                            end
                        end
                    endcase
                    set_nz(r);
                    nzcv.c   = c;
                    res.we   = 1'b1;
                    res.widx = {1'b0, op[2:0]};
                    res.wval = r;
                end
            end
            tabe_pkg::CLS_IMM8: begin
                a = read_gpr({1'b0, op[10:8]}, pc);
                b = {24'd0, op[7:0]};
                case (thumb_exec_codes_pkg::imm8_kind_t'(op[12:11]))
                    thumb_exec_codes_pkg::IMM_MOV: begin
                        res.wval = b;
                        set_nz(b);
                        res.we = 1'b1;
                    end
                    thumb_exec_codes_pkg::IMM_CMP: r = sub_nzcv(a, b);
                    thumb_exec_codes_pkg::IMM_ADD: begin
                        res.wval = add_nzcv(a, b);
                        res.we   = 1'b1;
                    end
                    default: begin
                        res.wval = sub_nzcv(a, b);
                        res.we   = 1'b1;
                    end
                endcase
                if (res.we) res.widx = {1'b0, op[10:8]};
            end
            tabe_pkg::CLS_ALU: begin
                a = read_gpr({1'b0, op[2:0]}, pc);
                b = read_gpr({1'b0, op[5:3]}, pc);
                case (thumb_exec_codes_pkg::alu_op_t'(op[9:6]))
                    thumb_exec_codes_pkg::ALU_CMP: r = sub_nzcv(a, b);
                    thumb_exec_codes_pkg::ALU_BIC: begin
                        res.wval = a & ~b;
                        set_nz(res.wval);
                        res.we   = 1'b1;
                        res.widx = {1'b0, op[2:0]};
                    end
                    default: res.unsup = 1'b1;
                endcase
            end
            tabe_pkg::CLS_HIREG: begin
                src = {op[6], op[5:3]};
                dst = {op[7], op[2:0]};
                a   = read_gpr(src, pc);
                case (thumb_exec_codes_pkg::hireg_kind_t'(op[9:8]))
                    thumb_exec_codes_pkg::HI_MOV: begin
                        // a move into the pc is a branch, not a write
                        if (dst == tabe_pkg::PcIdx) begin
                            res.taken = 1'b1;
                            res.npc   = a & ~32'd1;
                        end else begin
                            res.we   = 1'b1;
                            res.widx = dst;
                            res.wval = a;
                        end
                    end
                    thumb_exec_codes_pkg::HI_BX: begin
                        res.taken = 1'b1;
                        res.npc   = a & ~32'd1;
                        res.thumb = a[0];
                    end
                    default: res.unsup = 1'b1;
                endcase
            end
            tabe_pkg::CLS_BCOND: begin
                if (op[11:8] >= thumb_exec_codes_pkg::COND_AL) begin
                    res.unsup = 1'b1;
                end else if (cond_holds(thumb_exec_codes_pkg::cond_t'(op[11:8]))) begin
                    res.taken = 1'b1;
                    res.npc   = pc + 32'd2 + {{23{op[7]}}, op[7:0], 1'b0};
                end
            end
            tabe_pkg::CLS_BL_HI: begin
                res.we   = 1'b1;
                res.widx = tabe_pkg::LrIdx;
                res.wval = pc + 32'd2 + {{9{op[10]}}, op[10:0], 12'd0};
            end
            tabe_pkg::CLS_BL_LO: begin
                // target uses the link register before it is overwritten
                res.taken = 1'b1;
                res.npc   = gpr[tabe_pkg::LrIdx] + {20'd0, op[10:0], 1'b0};
                res.we    = 1'b1;
                res.widx  = tabe_pkg::LrIdx;
                res.wval  = pc | 32'd1;
            end
            default: res.unsup = 1'b1;
        endcase
        if (res.we) gpr[res.widx] = res.wval;
        res.flags = nzcv;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %08h, want %08h",
                                      results_checked, name, got, want));
    endtask

    // compare each result transaction against the oldest prediction, then predict new input
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tabe_pkg::RegCount; i++) gpr[i] = 32'd0;
            nzcv = '0;
            pending_results.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding, next_pc %08h",
                                              m_next_pc));
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("reg_write_en", 32'(m_reg_write_en), 32'(oldest.we));
                    check_field("write_reg", 32'(m_write_reg), 32'(oldest.widx));
                    check_field("reg_value", m_reg_value, oldest.wval);
                    check_field("flag_n", 32'(m_flag_n), 32'(oldest.flags.n));
                    check_field("flag_z", 32'(m_flag_z), 32'(oldest.flags.z));
                    check_field("flag_c", 32'(m_flag_c), 32'(oldest.flags.c));
                    check_field("flag_v", 32'(m_flag_v), 32'(oldest.flags.v));
                    check_field("branch_taken", 32'(m_branch_taken), 32'(oldest.taken));
                    check_field("next_pc", m_next_pc, oldest.npc);
                    check_field("thumb_mode", 32'(m_thumb_mode), 32'(oldest.thumb));
                    check_field("unsupported", 32'(m_unsupported), 32'(oldest.unsup));
                    results_checked++;
                    if (oldest.taken) redirects_seen++;
                    if (!oldest.thumb) arm_exits_seen++;
                    if (oldest.unsup) unsupported_seen++;
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(execute_instr(s_instr, s_pc_value));
            pending <= pending_results.size();
        end
    end

endmodule

FILE: verif/thumb_alu_branch_execute_top_test.sv
// stimulus, idling and verdict for the thumb execute block regression
`timescale 1ns / 1ps

module thumb_alu_branch_execute_top_test;

    localparam int RESET_CYCLES     = 4;
    localparam int QUIET_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 64;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 155;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [15:0] s_instr    = 16'd0;
    logic [31:0] s_pc_value = 32'd0;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic        m_reg_write_en;
    logic [3:0]  m_write_reg;
    logic [31:0] m_reg_value;
    logic        m_flag_n;
    logic        m_flag_z;
    logic        m_flag_c;
    logic        m_flag_v;
    logic        m_branch_taken;
    logic [31:0] m_next_pc;
    logic        m_thumb_mode;
    logic        m_unsupported;

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    int   items_sent    = 0;
    int   directed_sent = 0;

    int fail_count;
    int pending;
    int results_checked;
    int redirects_seen;
    int arm_exits_seen;
    int unsupported_seen;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    thumb_alu_branch_execute_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_instr        (s_instr),
        .s_pc_value     (s_pc_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reg_write_en (m_reg_write_en),
        .m_write_reg    (m_write_reg),
        .m_reg_value    (m_reg_value),
        .m_flag_n       (m_flag_n),
        .m_flag_z       (m_flag_z),
        .m_flag_c       (m_flag_c),
        .m_flag_v       (m_flag_v),
        .m_branch_taken (m_branch_taken),
        .m_next_pc      (m_next_pc),
        .m_thumb_mode   (m_thumb_mode),
        .m_unsupported  (m_unsupported)
    );

    thumb_exec_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_instr          (s_instr),
        .s_pc_value       (s_pc_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_reg_write_en   (m_reg_write_en),
        .m_write_reg      (m_write_reg),
        .m_reg_value      (m_reg_value),
        .m_flag_n         (m_flag_n),
        .m_flag_z         (m_flag_z),
        .m_flag_c         (m_flag_c),
        .m_flag_v         (m_flag_v),
        .m_branch_taken   (m_branch_taken),
        .m_next_pc        (m_next_pc),
        .m_thumb_mode     (m_thumb_mode),
        .m_unsupported    (m_unsupported),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_checked  (results_checked),
        .redirects_seen   (redirects_seen),
        .arm_exits_seen   (arm_exits_seen),
        .unsupported_seen (unsupported_seen)
    );

    // result side: long hold-off on request, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("thumb_alu_branch_execute_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // encodings
    function automatic logic [15:0] fmt_shift(input thumb_exec_codes_pkg::shift_kind_t kind,
                                              input logic [4:0] imm5,
                                              input logic [2:0] rs, input logic [2:0] rd);
        return {3'b000, kind, imm5, rs, rd};
    endfunction

    function automatic logic [15:0] fmt_imm8(input thumb_exec_codes_pkg::imm8_kind_t kind,
                                             input logic [2:0] rd, input logic [7:0] imm);
        return {3'b001, kind, rd, imm};
    endfunction

    function automatic logic [15:0] fmt_alu(input thumb_exec_codes_pkg::alu_op_t aop,
                                            input logic [2:0] rs, input logic [2:0] rd);
        return {6'b010000, aop, rs, rd};
    endfunction

    function automatic logic [15:0] fmt_hireg(input thumb_exec_codes_pkg::hireg_kind_t kind,
                                              input logic [3:0] src, input logic [3:0] dst);
        return {6'b010001, kind, dst[3], src[3], src[2:0], dst[2:0]};
    endfunction

    function automatic logic [15:0] fmt_bcond(input thumb_exec_codes_pkg::cond_t cond,
                                              input logic [7:0] imm);
        return {4'b1101, cond, imm};
    endfunction

    function automatic logic [15:0] fmt_bl(input logic second, input logic [10:0] imm);
        return {4'b1111, second, imm};
    endfunction

    function automatic logic [2:0] lo_reg();
        return 3'($urandom_range(7));
    endfunction

    function automatic logic [7:0] random_imm8();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] random_pc();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    // mostly executable encodings with random operands, some raw noise
    function automatic logic [15:0] random_instr();
        int                            pick;
        logic [4:0]                    imm5;
        thumb_exec_codes_pkg::alu_op_t aop;
        pick = $urandom_range(99);
        imm5 = ($urandom_range(4) == 0) ? 5'd0 : 5'($urandom_range(31));
        if ($urandom_range(9) < 7)
            aop = ($urandom_range(1) == 0) ? thumb_exec_codes_pkg::ALU_CMP
                                           : thumb_exec_codes_pkg::ALU_BIC;
        else
            aop = thumb_exec_codes_pkg::alu_op_t'($urandom_range(15));
        if (pick < 20)
            return fmt_shift(thumb_exec_codes_pkg::shift_kind_t'($urandom_range(2)), imm5,
                             lo_reg(), lo_reg());
        else if (pick < 32)
            return fmt_shift(thumb_exec_codes_pkg::SH_ADDSUB,
                             {($urandom_range(6) == 0), 1'($urandom_range(1)), lo_reg()},
                             lo_reg(), lo_reg());
        else if (pick < 50)
            return fmt_imm8(thumb_exec_codes_pkg::imm8_kind_t'($urandom_range(3)), lo_reg(),
                            random_imm8());
        else if (pick < 62)
            return fmt_alu(aop, lo_reg(), lo_reg());
        else if (pick < 76)
            return fmt_hireg(thumb_exec_codes_pkg::hireg_kind_t'($urandom_range(3)),
                             4'($urandom_range(15)), 4'($urandom_range(15)));
        else if (pick < 90)
            return fmt_bcond(thumb_exec_codes_pkg::cond_t'($urandom_range(15)),
                             random_imm8());
        else
            return 16'($urandom);
    endfunction

    // one instruction transaction, with random idle cycles ahead of it
    task automatic send_instr(input logic [15:0] instr, input logic [31:0] pc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_instr    <= instr;
        s_pc_value <= pc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // either a single instruction or a well-formed branch-with-link pair
    task automatic send_random();
        logic [31:0] pc;
        pc = random_pc();
        if ($urandom_range(99) < 10) begin
            send_instr(fmt_bl(1'b0, 11'($urandom_range(2047))), pc);
            send_instr(fmt_bl(1'b1, 11'($urandom_range(2047))), pc + 32'd2);
        end else begin
            send_instr(random_instr(), pc);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, every supported operation and the corner cases
        send_instr(fmt_imm8(thumb_exec_codes_pkg::IMM_MOV, 3'd0, 8'hFF), 32'h0000_0000);
        send_instr(fmt_imm8(thumb_exec_codes_pkg::IMM_MOV, 3'd1, 8'h00), 32'hFFFF_FFFF);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_LSL, 5'd31, 3'd0, 3'd2),
                   32'h0000_0100);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_LSL, 5'd0, 3'd2, 3'd3),
                   32'h0000_0102);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_LSR, 5'd0, 3'd2, 3'd4),
                   32'h0000_0104);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_ASR, 5'd0, 3'd2, 3'd5),
                   32'h0000_0106);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_ASR, 5'd1, 3'd2, 3'd6),
                   32'h0000_0108);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_LSR, 5'd31, 3'd5, 3'd7),
                   32'h0000_010A);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_ADDSUB, {2'b00, 3'd2}, 3'd2, 3'd3),
                   32'h0000_010C);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_ADDSUB, {2'b01, 3'd0}, 3'd1, 3'd4),
                   32'h0000_010E);
        send_instr(fmt_shift(thumb_exec_codes_pkg::SH_ADDSUB, {2'b10, 3'd7}, 3'd0, 3'd0),
                   32'h0000_0110);
        send_instr(fmt_imm8(thumb_exec_codes_pkg::IMM_CMP, 3'd0, 8'hFF), 32'h0000_0112);
        send_instr(fmt_imm8(thumb_exec_codes_pkg::IMM_ADD, 3'd5, 8'h01), 32'h0000_0114);
        send_instr(fmt_imm8(thumb_exec_codes_pkg::IMM_SUB, 3'd6, 8'h80), 32'h0000_0116);
        send_instr(fmt_alu(thumb_exec_codes_pkg::ALU_CMP, 3'd0, 3'd4), 32'h0000_0118);
        send_instr(fmt_alu(thumb_exec_codes_pkg::ALU_BIC, 3'd0, 3'd5), 32'h0000_011A);
        send_instr(fmt_alu(thumb_exec_codes_pkg::ALU_MUL, 3'd1, 3'd2), 32'h0000_011C);
        send_instr(fmt_hireg(thumb_exec_codes_pkg::HI_MOV, tabe_pkg::PcIdx, 4'd8),
                   32'h1234_5679);
        send_instr(fmt_hireg(thumb_exec_codes_pkg::HI_MOV, 4'd8, tabe_pkg::PcIdx),
                   32'h0000_0120);
        send_instr(fmt_hireg(thumb_exec_codes_pkg::HI_BX, 4'd2, tabe_pkg::PcIdx),
                   32'h0000_0122);
        send_instr(fmt_hireg(thumb_exec_codes_pkg::HI_BX, 4'd7, 4'd0), 32'h0000_0124);
        send_instr(fmt_hireg(thumb_exec_codes_pkg::HI_ADD, 4'd9, 4'd1), 32'h0000_0126);
        send_instr(fmt_bcond(thumb_exec_codes_pkg::COND_EQ, 8'h80), 32'h0000_0000);
        send_instr(fmt_bcond(thumb_exec_codes_pkg::COND_AL, 8'h00), 32'h0000_012A);
        send_instr(fmt_bcond(thumb_exec_codes_pkg::COND_NV, 8'hFF), 32'h0000_012C);
        send_instr(fmt_bl(1'b0, 11'h400), 32'hFFFF_FFFE);
        send_instr(fmt_bl(1'b1, 11'h7FF), 32'h0000_0000);
        send_instr(16'h6000, 32'h0000_0130);
        directed_sent = items_sent;

        // random phases: receiver hold-off, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            send_idle_pct = (ph == 1) ? 87 : ((ph == 3) ? 30 : 0);
            stall_pct     = (ph == 2) ? 87 : ((ph == 3) ? 30 : 0);
            if (ph == 0) hold_req = 1'b1;
            @(negedge aclk);
            repeat (RANDOM_PER_PHASE) send_random();
        end
        s_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d instruction transactions (%0d directed) over four idling phases",
                 items_sent, directed_sent);
        $display("checked %0d results: %0d pc redirects, %0d exits to arm state, %0d unsupported",
                 results_checked, redirects_seen, arm_exits_seen, unsupported_seen);
        if (fail_count == 0)
            $display("thumb_alu_branch_execute_top regression: pass");
        else
            $display("thumb_alu_branch_execute_top regression: fail");
        $finish;
    end

endmodule
